/* hdl/lhp_pkg.sv */
// ----------------------------------------------------------------------------
// lhp_pkg
// Types and constants shared by the line hash partitioner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lhp_pkg;

	localparam logic [31:0] HASH_SEED    = 32'd5381;
	localparam logic [7:0]  NEWLINE_BYTE = 8'd10;
	localparam int unsigned HASH_W       = 32;
	localparam int unsigned BUCKET_W     = 16;

	// register indexes
	localparam logic REG_BUCKET_COUNT = 1'b0;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} lhp_in_t;

	typedef struct packed {
		logic [BUCKET_W-1:0] bucket;
		logic [HASH_W-1:0]   hash_low;
	} lhp_out_t;

	typedef struct packed {
		logic                start;
		logic [HASH_W-1:0]   hash;
		logic [BUCKET_W-1:0] divisor;
	} lhp_div_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [BUCKET_W-1:0] rem;
		logic [HASH_W-1:0]   hash;
	} lhp_div_rsp_t;

endpackage

`default_nettype wire

/* hdl/lhp_hash.sv */
// ----------------------------------------------------------------------------
// lhp_hash
// Per-line djb2 accumulator and chunk length counter; flags the end of a line.
// ----------------------------------------------------------------------------
`default_nettype none

module lhp_hash
	import lhp_pkg::*;
#(
	parameter int unsigned MAX_CHUNK = 4011
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              beat,
	input  wire lhp_in_t           item,
	output logic                   line_end,
	output logic [HASH_W-1:0]      line_hash
);

	localparam int unsigned LEN_W = $clog2(MAX_CHUNK + 1);

	logic [HASH_W-1:0] hash_q;
	logic              stopped_q;
	logic [LEN_W-1:0]  len_q;

	logic              is_newline;
	logic              stop_byte;
	logic [HASH_W-1:0] add;
	logic [HASH_W-1:0] hash_next;
	logic [LEN_W-1:0]  len_next;

	assign is_newline = (item.data_byte == NEWLINE_BYTE);
	assign stop_byte  = is_newline || (item.data_byte == 8'd0);
	// signed char add, only the low word of the hash ever reaches the output
	assign add        = {{(HASH_W-8){item.data_byte[7]}}, item.data_byte};
	assign len_next   = len_q + LEN_W'(1);

	always_comb begin
		hash_next = hash_q;
		if (!stopped_q && !stop_byte) begin
			hash_next = {hash_q[HASH_W-6:0], 5'd0} + hash_q + add;
		end
	end

	assign line_end  = is_newline || item.end_of_stream || (len_next == LEN_W'(MAX_CHUNK));
	assign line_hash = hash_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q    <= HASH_SEED;
			stopped_q <= 1'b0;
			len_q     <= '0;
		end else if (beat) begin
			if (line_end) begin
				hash_q    <= HASH_SEED;
				stopped_q <= 1'b0;
				len_q     <= '0;
			end else begin
				hash_q    <= hash_next;
				stopped_q <= stopped_q || stop_byte;
				len_q     <= len_next;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/lhp_divider.sv */
// ----------------------------------------------------------------------------
// lhp_divider
// Restoring remainder unit, one quotient bit per cycle, with a result hold.
// ----------------------------------------------------------------------------
`default_nettype none

module lhp_divider
	import lhp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire lhp_div_req_t req,
	input  wire logic         ack,
	output lhp_div_rsp_t      rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam int unsigned CNT_W = $clog2(HASH_W);

	logic [1:0]          state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [HASH_W-1:0]   dividend_q;
	logic [HASH_W-1:0]   hash_q;
	logic [BUCKET_W-1:0] divisor_q;
	logic [BUCKET_W-1:0] rem_q;

	logic [BUCKET_W:0]   rem_shift;
	logic [BUCKET_W:0]   rem_diff;
	logic [BUCKET_W-1:0] rem_next;

	assign rem_shift = {rem_q, dividend_q[HASH_W-1]};
	assign rem_diff  = rem_shift - {1'b0, divisor_q};
	assign rem_next  = (rem_shift >= {1'b0, divisor_q}) ? rem_diff[BUCKET_W-1:0]
	                                                     : rem_shift[BUCKET_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(HASH_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.start) begin
			dividend_q <= req.hash;
			hash_q     <= req.hash;
			// a zero count acts as one
			divisor_q  <= (req.divisor == '0) ? BUCKET_W'(1) : req.divisor;
			rem_q      <= '0;
		end else if (state_q == ST_RUN) begin
			dividend_q <= {dividend_q[HASH_W-2:0], 1'b0};
			rem_q      <= rem_next;
		end
	end

	assign rsp.busy = (state_q != ST_IDLE);
	assign rsp.done = (state_q == ST_DONE);
	assign rsp.rem  = rem_q;
	assign rsp.hash = hash_q;

endmodule

`default_nettype wire

/* hdl/line_hash_partitioner_unit.sv */
// ----------------------------------------------------------------------------
// line_hash_partitioner_unit
// Hashes text lines with djb2 and maps each line to a bucket by modulo.
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  byte      in   byte_valid/byte_stall   lhp_in_t  (data_byte, end_of_stream)
//  res       out  res_valid/res_stall     lhp_out_t (bucket, hash_low)
//  cfg       in   apb psel/penable/pready bucket_count at address 0
//
//  a byte that does not end a line does not raise byte_stall
//  a line-ending byte starts the remainder unit: byte_stall is then high through
//  its one-bit steps, one per hash bit, and the hand-off to the output register
//  a stalled result in the output register holds the hand-off and so
//  extends byte_stall
//  reset clears the line state and sets bucket_count to 1
// ----------------------------------------------------------------------------
`default_nettype none

module line_hash_partitioner_unit
	import lhp_pkg::*;
#(
	parameter int unsigned MAX_CHUNK = 4011
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire lhp_in_t     byte_data,
	output logic             res_valid,
	input  wire logic        res_stall,
	output lhp_out_t         res_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [BUCKET_W-1:0] bucket_count_q;
	logic                res_valid_q;
	lhp_out_t            res_data_q;

	logic                beat;
	logic                line_end;
	logic [HASH_W-1:0]   line_hash;
	logic                ack;
	lhp_div_req_t        div_req;
	lhp_div_rsp_t        div_rsp;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BUCKET_COUNT) ? {16'd0, bucket_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_W'(1);
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_BUCKET_COUNT) begin
			bucket_count_q <= pwdata[BUCKET_W-1:0];
		end
	end

	assign byte_stall = div_rsp.busy;
	assign beat       = byte_valid && !byte_stall;

	lhp_hash #(
		.MAX_CHUNK(MAX_CHUNK)
	) u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.beat     (beat),
		.item     (byte_data),
		.line_end (line_end),
		.line_hash(line_hash)
	);

	assign div_req.start   = beat && line_end;
	assign div_req.hash    = line_hash;
	assign div_req.divisor = bucket_count_q;

	lhp_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.ack   (ack),
		.rsp   (div_rsp)
	);

	assign ack = div_rsp.done && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ack) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			res_data_q.bucket   <= div_rsp.rem;
			res_data_q.hash_low <= div_rsp.hash;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

endmodule

`default_nettype wire

/* hdl/lhp_checker.sv */
// ----------------------------------------------------------------------------
// lhp_checker
// Port-level checks for the line hash partitioner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lhp_checker
	import lhp_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     byte_valid,
	input wire logic     byte_stall,
	input wire lhp_in_t  byte_data,
	input wire logic     res_valid,
	input wire logic     res_stall,
	input wire lhp_out_t res_data
);

	logic line_beat;
	assign line_beat = byte_valid && !byte_stall
		&& (byte_data.data_byte == NEWLINE_BYTE || byte_data.end_of_stream);

	// a stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result beat changed while stalled");

	// remainder unit takes the input side right after a line ends
	a_line_stall: assert property (@(posedge clk) disable iff (!arst_n)
		line_beat |=> byte_stall)
		else $error("byte accepted right after a line end");

	a_line_stall_2: assert property (@(posedge clk) disable iff (!arst_n)
		line_beat |-> ##2 byte_stall)
		else $error("remainder unit finished too early");

	// bucket is always below a 16-bit count
	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.bucket != 16'hFFFF)
		else $error("bucket out of range");

endmodule

bind line_hash_partitioner_unit lhp_checker u_lhp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.byte_valid(byte_valid),
	.byte_stall(byte_stall),
	.byte_data (byte_data),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);

`default_nettype wire

/* dv/line_hash_partitioner_checker.sv */
// ----------------------------------------------------------------------------
// line_hash_partitioner_checker
// Watches the byte, result and register channels of the line hash
// partitioner. Keeps its own djb2 line state and bucket count, predicts the
// bucket and hash of every line that a byte beat closes, and compares each
// result beat with the oldest prediction. Register reads are checked too.
// ----------------------------------------------------------------------------
module line_hash_partitioner_checker
	import lhp_pkg::*;
#(
	parameter int unsigned MAX_CHUNK = 4011
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic        byte_stall,
	input  lhp_in_t     byte_data,
	input  logic        res_valid,
	input  logic        res_stall,
	input  lhp_out_t    res_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          mismatches,
	output int          lines_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0]  BUCKET_COUNT_ADDR = {REG_BUCKET_COUNT, 2'b00};
	localparam logic [63:0] DJB2_SEED         = 64'd5381;

	logic [63:0] line_hash;
	logic        hash_halted;
	int unsigned chunk_len;
	logic [15:0] bucket_count;
	lhp_out_t    expected_lines[$];

	task automatic start_line();
		line_hash   = DJB2_SEED;
		hash_halted = 1'b0;
		chunk_len   = 0;
	endtask

	task automatic hash_beat(input lhp_in_t beat);
		logic [31:0] low;
		logic [31:0] divisor;
		lhp_out_t    line;
		// zero byte or newline freezes the hash, the line keeps counting
		if (!hash_halted) begin
			if (beat.data_byte == 8'd0 || beat.data_byte == NEWLINE_BYTE)
				hash_halted = 1'b1;
			else
				line_hash = line_hash * 64'd33 + {{56{beat.data_byte[7]}}, beat.data_byte};
		end
		chunk_len++;
		if (beat.data_byte == NEWLINE_BYTE || beat.end_of_stream || chunk_len >= MAX_CHUNK) begin
			low           = line_hash[31:0];
			divisor       = (bucket_count == 16'd0) ? 32'd1 : {16'd0, bucket_count};
			line.bucket   = 16'(low % divisor);
			line.hash_low = low;
			expected_lines.push_back(line);
			start_line();
		end
	endtask

	task automatic check_line(input lhp_out_t got);
		lhp_out_t want;
		if (expected_lines.size() == 0) begin
			$error("res_data: beat with no line pending, bucket %0d hash_low %h",
				got.bucket, got.hash_low);
			mismatches++;
		end else begin
			want = expected_lines.pop_front();
			if (got.bucket !== want.bucket) begin
				$error("bucket: expected %0d, actual %0d", want.bucket, got.bucket);
				mismatches++;
			end
			if (got.hash_low !== want.hash_low) begin
				$error("hash_low: expected %h, actual %h", want.hash_low, got.hash_low);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_line();
			bucket_count = 16'd1;
			mismatches   = 0;
			expected_lines.delete();
		end else begin
			if (res_valid && !res_stall)
				check_line(res_data);
			if (byte_valid && !byte_stall)
				hash_beat(byte_data);
			if (psel && penable && pready && paddr == BUCKET_COUNT_ADDR) begin
				if (pwrite) begin
					bucket_count = pwdata[15:0];
				end else if (prdata !== {16'd0, bucket_count}) begin
					$error("prdata: expected %h, actual %h", {16'd0, bucket_count}, prdata);
					mismatches++;
				end
			end
		end
		lines_owed = expected_lines.size();
	end

endmodule

/* dv/line_hash_partitioner_unit_test.sv */
// ----------------------------------------------------------------------------
// line_hash_partitioner_unit_test
// Drives text byte streams into the line hash partitioner: directed lines for
// sign extension, stopped hashing, end of stream and full chunks, then random
// lines and noise over several bucket counts, with bursty input, varied
// result stalls and one long hold-off. The checker does all comparison.
// ----------------------------------------------------------------------------
module line_hash_partitioner_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lhp_pkg::*;

	localparam int unsigned MAX_CHUNK         = 4011;
	localparam logic [2:0]  BUCKET_COUNT_ADDR = {REG_BUCKET_COUNT, 2'b00};
	localparam int          SETTLE_CYCLES     = 48;
	localparam int          HOLD_CYCLES       = 400;
	localparam int          PHASE_BYTES       = 125;
	localparam int          PHASES            = 8;
	localparam longint      TIMEOUT_NS        = 64'd40_000_000;

	typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_mode_e;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	lhp_in_t     byte_data  = '0;
	logic        res_valid;
	logic        res_stall  = 1'b0;
	lhp_out_t    res_data;
	logic        psel       = 1'b0;
	logic        penable    = 1'b0;
	logic        pwrite     = 1'b0;
	logic [2:0]  paddr      = '0;
	logic [31:0] pwdata     = '0;
	logic [31:0] prdata;
	logic        pready;
	int          mismatches;
	int          lines_owed;

	// sender shaping
	logic     bursty      = 1'b1;
	int       burst_left  = 0;
	int       bytes_sent  = 0;
	// receiver shaping
	rx_mode_e rx_mode     = RX_FREE;
	int       hold_asks   = 0;
	int       hold_seen   = 0;
	int       hold_left   = 0;
	int       rx_cycle    = 0;

	always #5 clk = ~clk;

	line_hash_partitioner_unit #(
		.MAX_CHUNK(MAX_CHUNK)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data (byte_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	line_hash_partitioner_checker #(
		.MAX_CHUNK(MAX_CHUNK)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data (byte_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.mismatches(mismatches),
		.lines_owed(lines_owed)
	);

	// receiver stall pattern, with a counted hold-off on request
	always @(negedge clk) begin
		rx_cycle++;
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			res_stall = 1'b1;
			hold_left--;
		end else begin
			case (rx_mode)
				RX_FREE:     res_stall = 1'b0;
				RX_RANDOM:   res_stall = ($urandom_range(0, 99) < 35);
				RX_PERIODIC: res_stall = ((rx_cycle % 7) < 3);
				default:     res_stall = ($urandom_range(0, 99) < 80);
			endcase
		end
	end

	// all tasks below start and end at a falling edge
	task automatic send_beat(input logic [7:0] b, input logic eos);
		if (bursty && burst_left == 0) begin
			byte_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		byte_data.data_byte     = b;
		byte_data.end_of_stream = eos;
		byte_valid              = 1'b1;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		@(negedge clk);
		if (burst_left > 0)
			burst_left--;
		bytes_sent++;
	endtask

	task automatic drain();
		byte_valid = 1'b0;
		wait (lines_owed == 0);
		@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reg_access(input logic wr, input logic [31:0] data);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = BUCKET_COUNT_ADDR;
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic set_buckets(input logic [15:0] count);
		reg_access(1'b1, {16'($urandom), count});
		reg_access(1'b0, $urandom);
	endtask

	task automatic send_chunk(input int len, input logic any_byte);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = any_byte ? 8'($urandom_range(0, 255)) : 8'($urandom_range(11, 255));
			if (b == NEWLINE_BYTE)
				b = 8'h0b;
			send_beat(b, 1'b0);
		end
	endtask

	task automatic send_random_line();
		int         len;
		int         pick;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		if (pick < 85)
			len = $urandom_range(0, 24);
		else if (pick < 97)
			len = $urandom_range(25, 160);
		else
			len = $urandom_range(161, 700);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				b = 8'($urandom_range(32, 126));
			else if (pick < 66)
				b = 8'd0;
			else
				b = 8'($urandom_range(0, 255));
			if (b == NEWLINE_BYTE)
				b = 8'h20;
			send_beat(b, 1'b0);
		end
		pick = $urandom_range(0, 99);
		if (pick < 8)
			send_beat(8'($urandom_range(11, 255)), 1'b1);
		else if (pick < 12)
			send_beat(NEWLINE_BYTE, 1'b1);
		else
			send_beat(NEWLINE_BYTE, 1'b0);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(10, 60))
			send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 3);
	endtask

	initial begin
		#(TIMEOUT_NS);
		$display("line_hash_partitioner_unit: mismatch");
		$finish;
	end

	initial begin
		logic [15:0] count;
		int          start_bytes;

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset value of the bucket count
		reg_access(1'b0, 32'd0);
		send_beat("A", 1'b0);
		send_beat(NEWLINE_BYTE, 1'b0);
		drain();

		// zero bucket count behaves as one
		set_buckets(16'd0);
		send_beat("h", 1'b0);
		send_beat(8'hC3, 1'b0);
		send_beat(NEWLINE_BYTE, 1'b0);
		drain();

		set_buckets(16'hFFFF);
		send_beat("A", 1'b0);
		send_beat(NEWLINE_BYTE, 1'b0);
		// newline that also ends the stream
		send_beat(NEWLINE_BYTE, 1'b1);
		send_beat(NEWLINE_BYTE, 1'b0);
		// sign extension extremes
		send_beat(8'hFF, 1'b0);
		send_beat(8'h80, 1'b0);
		send_beat(8'h7F, 1'b0);
		send_beat(8'h01, 1'b0);
		send_beat(NEWLINE_BYTE, 1'b0);
		// bytes after a zero byte are counted, not hashed
		send_beat("q", 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat("a", 1'b0);
		send_beat(8'hFE, 1'b0);
		send_beat(NEWLINE_BYTE, 1'b0);
		send_beat("x", 1'b1);
		send_beat(8'h00, 1'b1);
		// full chunk, then a newline that forms a line of its own
		send_chunk(MAX_CHUNK, 1'b0);
		send_beat(NEWLINE_BYTE, 1'b0);
		// full chunk with hashing stopped early
		send_beat("z", 1'b0);
		send_beat(8'h00, 1'b0);
		send_chunk(MAX_CHUNK - 2, 1'b1);
		send_beat("k", 1'b1);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:       count = 16'd2;
				1:       count = 16'hFFFF;
				2:       count = 16'd3;
				3:       count = 16'($urandom_range(1, 65535));
				4:       count = 16'h8000;
				5:       count = 16'd0;
				6:       count = 16'd1;
				default: count = 16'd251;
			endcase
			set_buckets(count);
			bursty  = (ph % 3) != 2;
			rx_mode = rx_mode_e'(ph % 4);
			// long result hold-off while bytes keep coming
			if (ph == 3)
				hold_asks++;
			start_bytes = bytes_sent;
			while (bytes_sent - start_bytes < PHASE_BYTES) begin
				if ($urandom_range(0, 9) == 0)
					send_noise();
				else
					send_random_line();
			end
			send_beat(NEWLINE_BYTE, 1'b0);
			drain();
		end

		if (mismatches == 0 && lines_owed == 0)
			$display("line_hash_partitioner_unit: match");
		else
			$display("line_hash_partitioner_unit: mismatch");
		$finish;
	end

endmodule

/* line_hash_partitioner_unit.f */
hdl/lhp_pkg.sv
hdl/lhp_hash.sv
hdl/lhp_divider.sv
hdl/line_hash_partitioner_unit.sv
hdl/lhp_checker.sv
dv/line_hash_partitioner_checker.sv
dv/line_hash_partitioner_unit_test.sv
